// ===== design/rsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbm_pkg
// Shared types, constants and helpers for the RGB to spectrum basis mixer.
// ----------------------------------------------------------------------------
package rsbm_pkg;

	// Number of wavelength samples held per basis spectrum
	localparam int NUM_SAMPLES = 128;
	localparam int NUM_BASES   = 7;

	// Field widths fixed by the interface
	localparam int IDX_W    = 7;
	localparam int Q15_W    = 16;
	localparam int SAMPLE_W = 20;
	localparam int PROD_W   = 17;

	// Address width of one basis RAM, and the width used for range checks
	localparam int ADDR_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_CONVERT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		BASIS_WHITE   = 3'd0,
		BASIS_RED     = 3'd1,
		BASIS_GREEN   = 3'd2,
		BASIS_BLUE    = 3'd3,
		BASIS_CYAN    = 3'd4,
		BASIS_MAGENTA = 3'd5,
		BASIS_YELLOW  = 3'd6
	} basis_t;

	typedef logic [Q15_W-1:0]  q15_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef q15_t [NUM_BASES-1:0] basis_vec_t;

	// Input word
	typedef struct packed {
		op_t                 op;
		logic [2:0]          basis_select;
		logic [IDX_W-1:0]    sample_index;
		q15_t                basis_value;
		q15_t                red;
		q15_t                green;
		q15_t                blue;
		logic [SAMPLE_W-1:0] prior_sample;
	} in_item_t;

	// Output word
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic [IDX_W-1:0]    out_index;
		logic                saturated;
	} out_item_t;

	// Product stage contents handed from the mixer to the accumulator
	typedef struct packed {
		logic [PROD_W-1:0]   prod_white;
		logic [PROD_W-1:0]   prod_sec;
		logic [PROD_W-1:0]   prod_pri;
		logic [SAMPLE_W-1:0] prior;
		logic [IDX_W-1:0]    index;
	} mix_t;

	// Sample index to RAM address
	function automatic addr_t to_addr(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(idx);
		return ext[ADDR_W-1:0];
	endfunction

	// Sample index lies inside the stored spectra
	function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(idx);
		return ext < CMP_W'(NUM_SAMPLES);
	endfunction

endpackage

// ===== design/rsbm_basis_ram.sv =====
// ----------------------------------------------------------------------------
// rsbm_basis_ram
// One basis spectrum: NUM_SAMPLES x 16 bit, one write and one registered read.
// ----------------------------------------------------------------------------
module rsbm_basis_ram (
	input  logic          clk,
	input  logic          we,
	input  rsbm_pkg::addr_t waddr,
	input  rsbm_pkg::q15_t  wdata,
	input  logic          re,
	input  rsbm_pkg::addr_t raddr,
	output rsbm_pkg::q15_t  rdata
);
	import rsbm_pkg::*;

	q15_t mem_q [NUM_SAMPLES];
	q15_t rdata_q;

	// Contents are undefined until written; no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rsbm_mix.sv =====
// ----------------------------------------------------------------------------
// rsbm_mix
// Sorts the color channels, picks the white, secondary and primary basis
// values and registers the three truncated Q2.15 products.
// ----------------------------------------------------------------------------
module rsbm_mix (
	input  logic                          clk,
	input  logic                          en,
	input  rsbm_pkg::q15_t                red,
	input  rsbm_pkg::q15_t                green,
	input  rsbm_pkg::q15_t                blue,
	input  logic                          in_range,
	input  logic [rsbm_pkg::SAMPLE_W-1:0] prior,
	input  logic [rsbm_pkg::IDX_W-1:0]    index,
	input  rsbm_pkg::basis_vec_t          basis,
	output rsbm_pkg::mix_t                mix
);
	import rsbm_pkg::*;

	mix_t   mix_s2;
	basis_t sec_sel;
	basis_t pri_sel;
	q15_t   coef_white;
	q15_t   coef_sec;
	q15_t   coef_pri;
	q15_t   val_white;
	q15_t   val_sec;
	q15_t   val_pri;
	logic [2*Q15_W-1:0] p_white;
	logic [2*Q15_W-1:0] p_sec;
	logic [2*Q15_W-1:0] p_pri;

	// Minimum channel and sorted differences
	always_comb begin
		if (red <= green && red <= blue) begin
			coef_white = red;
			sec_sel    = BASIS_CYAN;
			if (green <= blue) begin
				coef_sec = green - red;
				pri_sel  = BASIS_BLUE;
				coef_pri = blue - green;
			end else begin
				coef_sec = blue - red;
				pri_sel  = BASIS_GREEN;
				coef_pri = green - blue;
			end
		end else if (green <= red && green <= blue) begin
			coef_white = green;
			sec_sel    = BASIS_MAGENTA;
			if (red <= blue) begin
				coef_sec = red - green;
				pri_sel  = BASIS_BLUE;
				coef_pri = blue - red;
			end else begin
				coef_sec = blue - green;
				pri_sel  = BASIS_RED;
				coef_pri = red - blue;
			end
		end else begin
			coef_white = blue;
			sec_sel    = BASIS_YELLOW;
			if (red <= green) begin
				coef_sec = red - blue;
				pri_sel  = BASIS_GREEN;
				coef_pri = green - red;
			end else begin
				coef_sec = green - blue;
				pri_sel  = BASIS_RED;
				coef_pri = red - green;
			end
		end
	end

	// Basis pick; an index outside the spectra reads as zero
	always_comb begin
		if (in_range) begin
			val_white = basis[BASIS_WHITE];
			val_sec   = basis[sec_sel];
			val_pri   = basis[pri_sel];
		end else begin
			val_white = '0;
			val_sec   = '0;
			val_pri   = '0;
		end
	end

	assign p_white = (2*Q15_W)'(val_white) * (2*Q15_W)'(coef_white);
	assign p_sec   = (2*Q15_W)'(val_sec)   * (2*Q15_W)'(coef_sec);
	assign p_pri   = (2*Q15_W)'(val_pri)   * (2*Q15_W)'(coef_pri);

	// Product register, truncated to Q2.15
	always_ff @(posedge clk) begin
		if (en) begin
			mix_s2.prod_white <= p_white[2*Q15_W-1:Q15_W-1];
			mix_s2.prod_sec   <= p_sec[2*Q15_W-1:Q15_W-1];
			mix_s2.prod_pri   <= p_pri[2*Q15_W-1:Q15_W-1];
			mix_s2.prior      <= prior;
			mix_s2.index      <= index;
		end
	end

	assign mix = mix_s2;

endmodule

// ===== design/rsbm_accum.sv =====
// ----------------------------------------------------------------------------
// rsbm_accum
// Adds the three products onto the prior sample and saturates to Q5.15.
// ----------------------------------------------------------------------------
module rsbm_accum (
	input  logic                clk,
	input  logic                en,
	input  rsbm_pkg::mix_t      mix,
	output rsbm_pkg::out_item_t result
);
	import rsbm_pkg::*;

	localparam int SUM_W = SAMPLE_W + 1;

	logic [SUM_W-1:0] sum;
	logic             clip;
	out_item_t        result_s3;

	// Max sum is below 2^21, so one extra bit is enough
	assign sum = SUM_W'(mix.prior) + SUM_W'(mix.prod_white)
		+ SUM_W'(mix.prod_sec) + SUM_W'(mix.prod_pri);
	assign clip = sum > SUM_W'(SAMPLE_MAX);

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3.sample_out <= clip ? SAMPLE_MAX : sum[SAMPLE_W-1:0];
			result_s3.out_index  <= mix.index;
			result_s3.saturated  <= clip;
		end
	end

	assign result = result_s3;

endmodule

// ===== design/rgb_to_spectrum_basis_mix.sv =====
// ----------------------------------------------------------------------------
// rgb_to_spectrum_basis_mix
// Smits-style RGB to spectrum mixer, one wavelength sample per convert word.
// ----------------------------------------------------------------------------
// Takes one input word per cycle while in_ready is high and returns one
// result per convert word after the basis RAM read, product register and
// output register; load words with a basis select below seven write one
// basis entry and return nothing. The seven basis spectra sit in seven RAMs
// of NUM_SAMPLES entries, each read once per convert word at the sample
// index, which sets the rate at one word per cycle. Basis RAMs are not
// cleared at reset: every entry a convert word uses must have been loaded
// first. A load followed at once by a convert of the same entry sees the
// new value. While out_ready is low, words still move up into empty stages;
// in_ready drops only once all three stages hold convert words.
// ----------------------------------------------------------------------------
module rgb_to_spectrum_basis_mix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsbm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rsbm_pkg::out_item_t out_data
);
	import rsbm_pkg::*;

	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                en1;
	logic                en2;
	logic                en3;
	logic                in_acc;
	logic                is_load;
	logic                is_conv;
	logic                in_range;
	addr_t               addr;
	q15_t                red_s1;
	q15_t                green_s1;
	q15_t                blue_s1;
	logic [SAMPLE_W-1:0] prior_s1;
	logic [IDX_W-1:0]    index_s1;
	logic                in_range_s1;
	basis_vec_t          basis_rd_s1;
	mix_t                mix_s2;

	// Stall chain: a stage moves when it is empty or the next one moves
	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;
	assign in_acc   = in_valid && in_ready;

	assign is_load  = in_data.op == OP_LOAD;
	assign is_conv  = in_data.op == OP_CONVERT;
	assign in_range = idx_in_range(in_data.sample_index);
	assign addr     = to_addr(in_data.sample_index);

	// Basis store, one RAM per spectrum
	for (genvar gi = 0; gi < NUM_BASES; gi++) begin : g_basis
		rsbm_basis_ram u_ram (
			.clk   (clk),
			.we    (in_acc && is_load && in_range && in_data.basis_select == 3'(gi)),
			.waddr (addr),
			.wdata (in_data.basis_value),
			.re    (in_acc && is_conv),
			.raddr (addr),
			.rdata (basis_rd_s1[gi])
		);
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid && is_conv;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Input register for convert words
	always_ff @(posedge clk) begin
		if (in_acc && is_conv) begin
			red_s1      <= in_data.red;
			green_s1    <= in_data.green;
			blue_s1     <= in_data.blue;
			prior_s1    <= in_data.prior_sample;
			index_s1    <= in_data.sample_index;
			in_range_s1 <= in_range;
		end
	end

	rsbm_mix u_mix (
		.clk      (clk),
		.en       (en2),
		.red      (red_s1),
		.green    (green_s1),
		.blue     (blue_s1),
		.in_range (in_range_s1),
		.prior    (prior_s1),
		.index    (index_s1),
		.basis    (basis_rd_s1),
		.mix      (mix_s2)
	);

	rsbm_accum u_accum (
		.clk    (clk),
		.en     (en3),
		.mix    (mix_s2),
		.result (out_data)
	);

	assign out_valid = valid_s3;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB to spectrum basis mixer.
// ----------------------------------------------------------------------------
// Loads basis spectra and drives convert words over the valid/ready input.
// A scoreboard keeps its own copy of the seven basis spectra and predicts
// every result. Each output word is compared field by field with the oldest
// prediction. Converts only ever touch sample positions whose seven basis
// entries are all loaded. Sender gaps and receiver stalls change phase by
// phase, and one long receiver hold-off backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsbm_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_WORDS    = 425;
	localparam int DRAIN_CYCLES   = 20;

	// Predicts mixer output and holds the samples still owed by the block
	class spectrum_scoreboard;
		q15_t      basis_ram [NUM_BASES][NUM_SAMPLES];
		out_item_t pending_samples[$];
		int        errors;
		int        checked;
		int        loads;
		int        saturations;

		function void flag_error(string msg);
			errors++;
			if (errors <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		// One truncated Q2.15 product of a basis entry and a channel difference
		function logic [31:0] scaled_basis(basis_t sel, logic [IDX_W-1:0] idx, q15_t coef);
			logic [31:0] prod;
			prod = 32'(basis_ram[int'(sel)][int'(idx)]) * 32'(coef);
			return prod >> 15;
		endfunction

		function out_item_t mix_sample(in_item_t w);
			out_item_t        res;
			logic [31:0]      sum;
			q15_t             r, g, b;
			logic [IDX_W-1:0] i;
			r   = w.red;
			g   = w.green;
			b   = w.blue;
			i   = w.sample_index;
			sum = 32'(w.prior_sample);
			// Smallest channel picks white share, then secondary and primary
			if (r <= g && r <= b) begin
				sum += scaled_basis(BASIS_WHITE, i, r);
				if (g <= b) begin
					sum += scaled_basis(BASIS_CYAN, i, g - r);
					sum += scaled_basis(BASIS_BLUE, i, b - g);
				end else begin
					sum += scaled_basis(BASIS_CYAN, i, b - r);
					sum += scaled_basis(BASIS_GREEN, i, g - b);
				end
			end else if (g <= r && g <= b) begin
				sum += scaled_basis(BASIS_WHITE, i, g);
				if (r <= b) begin
					sum += scaled_basis(BASIS_MAGENTA, i, r - g);
					sum += scaled_basis(BASIS_BLUE, i, b - r);
				end else begin
					sum += scaled_basis(BASIS_MAGENTA, i, b - g);
					sum += scaled_basis(BASIS_RED, i, r - b);
				end
			end else begin
				sum += scaled_basis(BASIS_WHITE, i, b);
				if (r <= g) begin
					sum += scaled_basis(BASIS_YELLOW, i, r - b);
					sum += scaled_basis(BASIS_GREEN, i, g - r);
				end else begin
					sum += scaled_basis(BASIS_YELLOW, i, g - b);
					sum += scaled_basis(BASIS_RED, i, r - g);
				end
			end
			// Clip at the Q5.15 top
			res.saturated = 1'b0;
			if (sum > 32'(SAMPLE_MAX)) begin
				sum           = 32'(SAMPLE_MAX);
				res.saturated = 1'b1;
			end
			res.sample_out = sum[SAMPLE_W-1:0];
			res.out_index  = i;
			return res;
		endfunction

		// Accepted input word: loads update the store, converts owe a sample
		function void note_word(in_item_t w);
			if (w.op == OP_LOAD) begin
				loads++;
				if (int'(w.basis_select) < NUM_BASES && int'(w.sample_index) < NUM_SAMPLES)
					basis_ram[int'(w.basis_select)][int'(w.sample_index)] = w.basis_value;
			end else begin
				pending_samples.push_back(mix_sample(w));
			end
		endfunction

		// Accepted output word against the oldest owed sample
		function void check_word(out_item_t got);
			out_item_t want;
			if (pending_samples.size() == 0) begin
				flag_error($sformatf("unexpected sample idx %0d value %h sat %b",
					got.out_index, got.sample_out, got.saturated));
				return;
			end
			want = pending_samples.pop_front();
			checked++;
			if (want.saturated)
				saturations++;
			if (got.sample_out !== want.sample_out)
				flag_error($sformatf("sample_out idx %0d: expected %h, got %h",
					want.out_index, want.sample_out, got.sample_out));
			if (got.out_index !== want.out_index)
				flag_error($sformatf("out_index: expected %0d, got %0d",
					want.out_index, got.out_index));
			if (got.saturated !== want.saturated)
				flag_error($sformatf("saturated idx %0d: expected %b, got %b",
					want.out_index, want.saturated, got.saturated));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	spectrum_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_start;
	int hold_cnt;
	int words_sent;

	// Which basis entries have been loaded, and positions safe to convert
	bit loaded [NUM_BASES][NUM_SAMPLES];
	bit idx_done [NUM_SAMPLES];
	int complete_idx[$];
	int build_idx;

	rgb_to_spectrum_basis_mix u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout after %0d cycles", TIMEOUT_CYCLES);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: check accepted words, then pick next ready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && out_ready)
					sb.check_word(out_data);
				if (hold_start) begin
					hold_cnt   = HOLD_CYCLES;
					hold_start = 1'b0;
				end
				if (hold_cnt > 0) begin
					hold_cnt--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= ($urandom_range(99) >= recv_stall_pct);
				end
			end
		end
	end

	function automatic in_item_t make_load(logic [2:0] sel, int idx, q15_t val);
		in_item_t w;
		w.op           = OP_LOAD;
		w.basis_select = sel;
		w.sample_index = IDX_W'(idx);
		w.basis_value  = val;
		w.red          = q15_t'($urandom);
		w.green        = q15_t'($urandom);
		w.blue         = q15_t'($urandom);
		w.prior_sample = SAMPLE_W'($urandom);
		return w;
	endfunction

	function automatic in_item_t make_conv(int idx, q15_t r, q15_t g, q15_t b,
		logic [SAMPLE_W-1:0] prior);
		in_item_t w;
		w.op           = OP_CONVERT;
		w.basis_select = 3'($urandom);
		w.sample_index = IDX_W'(idx);
		w.basis_value  = q15_t'($urandom);
		w.red          = r;
		w.green        = g;
		w.blue         = b;
		w.prior_sample = prior;
		return w;
	endfunction

	// Random word: mostly converts on loaded positions, loads mostly fill new ones
	function automatic in_item_t rand_word();
		in_item_t            w;
		int                  sel;
		int                  idx;
		q15_t                r, g, b;
		logic [SAMPLE_W-1:0] prior;
		if (complete_idx.size() < 4 || $urandom_range(99) < 30) begin
			if ($urandom_range(99) < 75 && complete_idx.size() < NUM_SAMPLES) begin
				// Fill the missing bases of one position in order
				while (idx_done[build_idx])
					build_idx = $urandom_range(NUM_SAMPLES - 1);
				sel = 0;
				while (loaded[sel][build_idx])
					sel++;
				idx = build_idx;
			end else begin
				sel = $urandom_range(7);
				idx = $urandom_range(NUM_SAMPLES - 1);
			end
			return make_load(3'(sel), idx,
				($urandom_range(9) == 0) ? q15_t'('1) : q15_t'($urandom));
		end
		idx = complete_idx[$urandom_range(complete_idx.size() - 1)];
		r   = q15_t'($urandom);
		g   = q15_t'($urandom);
		b   = q15_t'($urandom);
		case ($urandom_range(9))
			0: begin
				g = r;
				b = r;
			end
			1: begin
				case ($urandom_range(2))
					0: g = r;
					1: b = g;
					default: r = b;
				endcase
			end
			2: begin
				r = $urandom_range(1) ? q15_t'('1) : q15_t'(0);
				g = $urandom_range(1) ? q15_t'('1) : q15_t'(0);
				b = $urandom_range(1) ? q15_t'('1) : q15_t'(0);
			end
			default: ;
		endcase
		case ($urandom_range(9))
			0: prior = '0;
			1, 2: prior = SAMPLE_MAX - SAMPLE_W'($urandom_range(150000));
			default: prior = SAMPLE_W'($urandom);
		endcase
		return make_conv(idx, r, g, b, prior);
	endfunction

	// Offer one word, hold it until taken, then book it
	task automatic send_word(input in_item_t w);
		int sel;
		int idx;
		bit full;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_word(w);
		words_sent++;
		sel = int'(w.basis_select);
		idx = int'(w.sample_index);
		if (w.op == OP_LOAD && sel < NUM_BASES) begin
			loaded[sel][idx] = 1'b1;
			full = 1'b1;
			for (int s = 0; s < NUM_BASES; s++)
				full &= loaded[s][idx];
			if (full && !idx_done[idx]) begin
				idx_done[idx] = 1'b1;
				complete_idx.push_back(idx);
			end
		end
	endtask

	// Stimulus
	initial begin
		q15_t dir_vals [NUM_BASES];
		dir_vals       = '{16'h8000, 16'h1234, 16'h4321, 16'h7FFF, 16'h0001, 16'hABCD, 16'h0000};
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_start     = 1'b0;
		hold_cnt       = 0;
		build_idx      = $urandom_range(NUM_SAMPLES - 1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale bases at the top position, mixed ones at zero
		for (int s = 0; s < NUM_BASES; s++)
			send_word(make_load(3'(s), NUM_SAMPLES - 1, '1));
		for (int s = 0; s < NUM_BASES; s++)
			send_word(make_load(3'(s), 0, dir_vals[s]));
		// Select seven is dropped
		send_word(make_load(3'(NUM_BASES), 0, '1));
		// All channels tied at full scale
		send_word(make_conv(NUM_SAMPLES - 1, '1, '1, '1, '0));
		// Each of the six channel orders
		send_word(make_conv(0, 16'h1000, 16'h2000, 16'h3000, 20'd12345));
		send_word(make_conv(0, 16'h1000, 16'h3000, 16'h2000, 20'd12345));
		send_word(make_conv(0, 16'h2000, 16'h1000, 16'h3000, 20'd12345));
		send_word(make_conv(0, 16'h3000, 16'h1000, 16'h2000, 20'd12345));
		send_word(make_conv(0, 16'h2000, 16'h3000, 16'h1000, 20'd12345));
		send_word(make_conv(0, 16'h3000, 16'h2000, 16'h1000, 20'd12345));
		// Clipped sum, and a sum landing exactly on the top
		send_word(make_conv(NUM_SAMPLES - 1, 16'h0000, 16'h8000, 16'hFFFF, SAMPLE_MAX));
		send_word(make_conv(NUM_SAMPLES - 1, 16'h0000, 16'h0000, 16'h0000, SAMPLE_MAX));
		// Red and green tied below blue
		send_word(make_conv(0, 16'h4000, 16'h4000, 16'h8000, 20'd0));

		// Random phases: no idling, sender gaps, receiver stalls, both
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = (p == 1) ? 46 : (p == 3) ? 25 : 0;
			recv_stall_pct = (p == 2) ? 46 : (p == 3) ? 25 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 0 && n == 150)
					hold_start = 1'b1;
				send_word(rand_word());
			end
		end
		in_valid <= 1'b0;

		// Drain, then watch for stray words
		while (sb.pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_samples.size() != 0)
			sb.flag_error($sformatf("%0d samples never returned", sb.pending_samples.size()));

		$display("Covered %0d words: %0d basis loads, %0d samples checked (%0d clipped)",
			words_sent, sb.loads, sb.checked, sb.saturations);
		$display("%0d positions fully loaded, %0d mismatches", complete_idx.size(), sb.errors);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
